### rtl/i2ctb_pkg.sv
// Shared types and constants of the I2C target byte buffer engine.
// Used by the controller, the datapath, the select decode and the top level.
`default_nettype none

package i2ctb_pkg;

    localparam int RX_DEPTH   = 16;
    localparam int TX_DEPTH   = 16;
    localparam int IDX_W      = 4;     // store and message index width
    localparam int CNT_W      = 5;     // counts reaching the store depth
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] NO_BYTE = 8'hFF;

    localparam logic MODE_BUS  = 1'b0;
    localparam logic MODE_HOST = 1'b1;

    localparam logic KIND_RESP = 1'b0;
    localparam logic KIND_MSG  = 1'b1;

    // register select bit of paddr (registers at byte 0 and 4)
    localparam logic REG_ENABLED   = 1'b0;
    localparam logic REG_TX_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        EV_READ_START  = 3'd0,
        EV_READ_ACK    = 3'd1,
        EV_READ_NACK   = 3'd2,
        EV_WRITE_START = 3'd3,
        EV_WRITE_BYTE  = 3'd4,
        EV_STOP        = 3'd5,
        EV_ERROR       = 3'd6,
        EV_UNKNOWN     = 3'd7
    } event_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic load_msg;
        logic load_resp;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic has_result;   // incoming item is a bus event while enabled
        logic stop_msgs;    // incoming item is a stop with stored bytes
        logic msg_last;     // message byte being loaded is the final one
        logic out_free;     // output register can take a new result
    } status_t;

endpackage

`default_nettype wire

### rtl/i2ctb_item_if.sv
// Input channel: one bus event or one host write to the transmit store.
// Depends on nothing else.
`default_nettype none

interface i2ctb_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [2:0] event_code;
    logic [7:0] rx_byte;
    logic [3:0] store_index;
    logic [7:0] store_data;

    modport source (output valid, mode, event_code, rx_byte, store_index, store_data,
                    input ready);
    modport sink   (input valid, mode, event_code, rx_byte, store_index, store_data,
                    output ready);
endinterface

`default_nettype wire

### rtl/i2ctb_result_if.sv
// Output channel: one bus response or one delivered message byte.
// Depends on nothing else.
`default_nettype none

interface i2ctb_result_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       ack_enable;
    logic       send_stop;
    logic       busy_res;
    logic [7:0] msg_byte;
    logic [3:0] msg_index;
    logic [4:0] msg_length;
    logic       last;

    modport source (output valid, result_kind, tx_byte, ack_enable, send_stop, busy_res,
                           msg_byte, msg_index, msg_length, last,
                    input ready);
    modport sink   (input valid, result_kind, tx_byte, ack_enable, send_stop, busy_res,
                          msg_byte, msg_index, msg_length, last,
                    output ready);
endinterface

`default_nettype wire

### rtl/i2ctb_ctrl.sv
// Sequencing FSM: accepts items, then loads message bytes and the bus response.
// Depends on i2ctb_pkg.
`default_nettype none

module i2ctb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire i2ctb_pkg::status_t status,
    output i2ctb_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MSG,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = item_valid;
                if (item_valid && status.has_result)
                begin
                    state_next = status.stop_msgs ? ST_MSG : ST_RESP;
                end
            end
            ST_MSG:
            begin
                if (status.out_free)
                begin
                    cmd.load_msg = 1'b1;
                    if (status.msg_last)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_resp = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/i2ctb_dpath.sv
// Datapath: config registers, transmit/receive stores, counters, output register.
// Depends on i2ctb_pkg and i2ctb_top_note; driven by i2ctb_ctrl commands.
`default_nettype none

module i2ctb_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // config port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [i2ctb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [i2ctb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [i2ctb_pkg::APB_DATA_W-1:0]    prdata,
    // item fields
    input  wire logic                                mode,
    input  wire logic [2:0]                          event_code,
    input  wire logic [7:0]                          rx_byte,
    input  wire logic [3:0]                          store_index,
    input  wire logic [7:0]                          store_data,
    // result register
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     result_kind,
    output logic      [7:0]                          tx_byte,
    output logic                                     ack_enable,
    output logic                                     send_stop,
    output logic                                     busy_res,
    output logic      [7:0]                          msg_byte,
    output logic      [3:0]                          msg_index,
    output logic      [4:0]                          msg_length,
    output logic                                     last,
    // control
    input  wire i2ctb_pkg::cmd_t                     cmd,
    output i2ctb_pkg::status_t                       status
);

    localparam int IW = i2ctb_pkg::IDX_W;
    localparam int CW = i2ctb_pkg::CNT_W;

    // config
    logic          enabled_reg,   enabled_next;
    logic [CW-1:0] tx_length_reg, tx_length_next;
    logic          cfg_wr;
    logic          sel_enabled;

    // engine state
    logic [CW-1:0] tx_position_reg, tx_position_next;
    logic [CW-1:0] rx_count_reg,    rx_count_next;
    logic          busy_reg,        busy_next;
    logic [IW-1:0] msg_idx_reg,     msg_idx_next;
    i2ctb_pkg::event_t ev_reg;
    logic          tx_hit_reg;

    // stores
    logic [7:0] tx_store_reg [i2ctb_pkg::TX_DEPTH];
    logic [7:0] rx_store_reg [i2ctb_pkg::RX_DEPTH];
    logic [7:0] tx_rdata_reg;
    logic [7:0] rx_rdata_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       kind_reg;
    logic [7:0] tx_byte_reg;
    logic       ack_reg;
    logic       stop_reg;
    logic       busy_out_reg;
    logic [7:0] msg_byte_reg;
    logic [IW-1:0] msg_index_reg;
    logic [CW-1:0] msg_length_reg;
    logic       last_reg;

    // incoming item decode
    i2ctb_pkg::event_t ev;
    logic          bus_go;
    logic          host_wr;
    logic [CW-1:0] pos_eff;
    logic [CW-1:0] tx_limit;
    logic          tx_hit;
    logic          rx_room;
    logic          rx_wr;
    logic [IW-1:0] rx_rd_addr;
    logic [IW-1:0] msg_idx_inc;

    assign ev       = i2ctb_pkg::event_t'(event_code);
    assign bus_go   = cmd.accept && (mode == i2ctb_pkg::MODE_BUS) && enabled_reg;
    assign host_wr  = cmd.accept && (mode == i2ctb_pkg::MODE_HOST);
    assign pos_eff  = (ev == i2ctb_pkg::EV_READ_START) ? '0 : tx_position_reg;
    assign tx_limit = (tx_length_reg > CW'(i2ctb_pkg::TX_DEPTH))
                      ? CW'(i2ctb_pkg::TX_DEPTH) : tx_length_reg;
    assign tx_hit   = ((ev == i2ctb_pkg::EV_READ_START) || (ev == i2ctb_pkg::EV_READ_ACK))
                      && (pos_eff < tx_limit);
    assign rx_room  = rx_count_reg < CW'(i2ctb_pkg::RX_DEPTH);
    assign rx_wr    = bus_go && (ev == i2ctb_pkg::EV_WRITE_BYTE) && rx_room;
    assign msg_idx_inc = msg_idx_reg + IW'(1);
    assign rx_rd_addr  = cmd.load_msg ? msg_idx_inc : '0;

    assign status.has_result = (mode == i2ctb_pkg::MODE_BUS) && enabled_reg;
    assign status.stop_msgs  = (ev == i2ctb_pkg::EV_STOP) && (rx_count_reg != '0);
    assign status.msg_last   = (CW'(msg_idx_reg) + CW'(1)) == rx_count_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // config access
    assign cfg_wr = psel && penable && pwrite;

    i2ctb_top_note u_sel (
        .paddr       (paddr),
        .sel_enabled (sel_enabled)
    );

    always_comb
    begin
        unique case (paddr[2])
            i2ctb_pkg::REG_ENABLED:   prdata = i2ctb_pkg::APB_DATA_W'(enabled_reg);
            i2ctb_pkg::REG_TX_LENGTH: prdata = i2ctb_pkg::APB_DATA_W'(tx_length_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        enabled_next   = enabled_reg;
        tx_length_next = tx_length_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                i2ctb_pkg::REG_ENABLED:   enabled_next   = pwdata[0];
                i2ctb_pkg::REG_TX_LENGTH: tx_length_next = pwdata[CW-1:0];
                default:                  enabled_next   = enabled_reg;
            endcase
        end
    end

    // event state updates
    always_comb
    begin
        tx_position_next = tx_position_reg;
        rx_count_next    = rx_count_reg;
        busy_next        = busy_reg;
        if (bus_go)
        begin
            case (ev)
                i2ctb_pkg::EV_READ_START,
                i2ctb_pkg::EV_READ_ACK:
                begin
                    tx_position_next = tx_hit ? pos_eff + CW'(1) : pos_eff;
                    busy_next        = 1'b1;
                end
                i2ctb_pkg::EV_WRITE_START:
                begin
                    rx_count_next = '0;
                    busy_next     = 1'b1;
                end
                i2ctb_pkg::EV_WRITE_BYTE:
                begin
                    if (rx_room)
                    begin
                        rx_count_next = rx_count_reg + CW'(1);
                    end
                    busy_next = 1'b1;
                end
                i2ctb_pkg::EV_ERROR:
                begin
                    busy_next = busy_reg;
                end
                default:
                begin
                    busy_next = 1'b0;  // nack, stop/restart, unknown
                end
            endcase
        end
        if (cfg_wr && sel_enabled)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        msg_idx_next = msg_idx_reg;
        if (cmd.accept)
        begin
            msg_idx_next = '0;
        end
        else if (cmd.load_msg)
        begin
            msg_idx_next = msg_idx_inc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_msg || cmd.load_resp)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            tx_length_reg   <= '0;
            tx_position_reg <= '0;
            rx_count_reg    <= '0;
            busy_reg        <= 1'b0;
            msg_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            enabled_reg     <= enabled_next;
            tx_length_reg   <= tx_length_next;
            tx_position_reg <= tx_position_next;
            rx_count_reg    <= rx_count_next;
            busy_reg        <= busy_next;
            msg_idx_reg     <= msg_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (bus_go)
        begin
            ev_reg     <= ev;
            tx_hit_reg <= tx_hit;
        end
    end

    // transmit store: host writes, one registered read per accepted event
    always_ff @(posedge clk)
    begin
        if (host_wr)
        begin
            tx_store_reg[store_index] <= store_data;
        end
        if (bus_go)
        begin
            tx_rdata_reg <= tx_store_reg[pos_eff[IW-1:0]];
        end
    end

    // receive store: one write per received byte, registered read for unloading
    always_ff @(posedge clk)
    begin
        if (rx_wr)
        begin
            rx_store_reg[rx_count_reg[IW-1:0]] <= rx_byte;
        end
        if (cmd.accept || cmd.load_msg)
        begin
            rx_rdata_reg <= rx_store_reg[rx_rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_msg)
        begin
            kind_reg       <= i2ctb_pkg::KIND_MSG;
            tx_byte_reg    <= i2ctb_pkg::NO_BYTE;
            ack_reg        <= 1'b1;
            stop_reg       <= 1'b0;
            busy_out_reg   <= busy_reg;
            msg_byte_reg   <= rx_rdata_reg;
            msg_index_reg  <= msg_idx_reg;
            msg_length_reg <= rx_count_reg;
            last_reg       <= 1'b0;
        end
        else if (cmd.load_resp)
        begin
            kind_reg       <= i2ctb_pkg::KIND_RESP;
            tx_byte_reg    <= tx_hit_reg ? tx_rdata_reg : i2ctb_pkg::NO_BYTE;
            ack_reg        <= (ev_reg != i2ctb_pkg::EV_ERROR);
            stop_reg       <= (ev_reg == i2ctb_pkg::EV_ERROR);
            busy_out_reg   <= busy_reg;
            msg_byte_reg   <= '0;
            msg_index_reg  <= '0;
            msg_length_reg <= (ev_reg == i2ctb_pkg::EV_STOP) ? rx_count_reg : '0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign tx_byte     = tx_byte_reg;
    assign ack_enable  = ack_reg;
    assign send_stop   = stop_reg;
    assign busy_res    = busy_out_reg;
    assign msg_byte    = msg_byte_reg;
    assign msg_index   = msg_index_reg;
    assign msg_length  = msg_length_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

### rtl/i2ctb_top_note.sv
// Config register select decode: flags an access to the enabled register.
// Depends on i2ctb_pkg; used by the datapath.
`default_nettype none

module i2ctb_top_note (
    input  wire logic [i2ctb_pkg::APB_ADDR_W-1:0] paddr,
    output logic                                  sel_enabled
);
    assign sel_enabled = (paddr[2] == i2ctb_pkg::REG_ENABLED);
endmodule

`default_nettype wire

### rtl/i2c_target_byte_buffer_engine.sv
// I2C target byte buffer engine, top level.
// Depends on i2ctb_pkg, i2ctb_item_if, i2ctb_result_if, i2ctb_ctrl, i2ctb_dpath.
`default_nettype none

// Takes decoded I2C target bus events and host writes into a 16-byte transmit
// store, one transfer at a time on the item channel. A host write (mode 1)
// lands in the transmit store in the cycle it is accepted and gives no result;
// bus events are dropped while 'enabled' is 0. Read start/ack events load the
// next transmit byte (0xff past tx_length, which is clamped to 16); write
// events fill a 16-byte receive store, saturating. A stop/restart unloads the
// n stored receive bytes as n message transfers and then one bus response.
// Timing: the item channel takes a transfer only while the sequencer is idle.
// A host write or an ignored event is done once accepted; a bus event with one
// response is accepted, then loads the result register, whose transmit byte
// comes from a registered store read; a stop with n stored bytes loads one
// message byte per cycle while the output register is free, paced by the
// single read port of the receive store, then the response. Results sit in an
// output register, so the next item is taken while the last response still
// waits downstream; a full output register stalls every load of a result.
// Config: APB write, registers at byte 0 (enabled, writing it clears busy)
// and byte 4 (tx_length); pready is tied high; write only while idle.
module i2c_target_byte_buffer_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [i2ctb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [i2ctb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [i2ctb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    i2ctb_item_if.sink                               item,
    i2ctb_result_if.source                           result
);

    i2ctb_pkg::cmd_t    cmd;
    i2ctb_pkg::status_t status;

    assign pready     = 1'b1;
    assign item.ready = cmd.in_ready;

    i2ctb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .status     (status),
        .cmd        (cmd)
    );

    i2ctb_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .mode        (item.mode),
        .event_code  (item.event_code),
        .rx_byte     (item.rx_byte),
        .store_index (item.store_index),
        .store_data  (item.store_data),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .result_kind (result.result_kind),
        .tx_byte     (result.tx_byte),
        .ack_enable  (result.ack_enable),
        .send_stop   (result.send_stop),
        .busy_res    (result.busy_res),
        .msg_byte    (result.msg_byte),
        .msg_index   (result.msg_index),
        .msg_length  (result.msg_length),
        .last        (result.last),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the I2C target byte buffer engine: directed and random
// bus events and host store writes, with a transaction-level predictor.
// Depends on i2ctb_pkg, i2ctb_item_if, i2ctb_result_if and the engine RTL.

module tb_top;

    // One input transfer as the bench sees it.
    typedef struct packed {
        logic              mode;
        i2ctb_pkg::event_t code;
        logic [7:0]        rx_byte;
        logic [3:0]        store_index;
        logic [7:0]        store_data;
    } bus_item_t;

    // One output transfer, field for field as on the result channel.
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       ack_enable;
        logic       send_stop;
        logic       busy;
        logic [7:0] msg_byte;
        logic [3:0] msg_index;
        logic [4:0] msg_length;
        logic       last;
    } response_t;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [i2ctb_pkg::APB_ADDR_W-1:0] paddr;
    logic [i2ctb_pkg::APB_DATA_W-1:0] pwdata;
    logic [i2ctb_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    i2ctb_item_if   item_ch();
    i2ctb_result_if result_ch();

    i2c_target_byte_buffer_engine uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow copy of the engine's registers and stores
    // ------------------------------------------------------------------
    logic       en_cfg;
    logic [4:0] txlen_cfg;
    logic [4:0] tx_pos;
    logic [4:0] rx_cnt;
    logic       busy_state;
    logic [7:0] rx_mem [i2ctb_pkg::RX_DEPTH];
    logic [7:0] tx_mem [i2ctb_pkg::TX_DEPTH];

    // responses still owed by the engine, oldest first
    response_t awaited_results[$];

    // bench control
    int bad_count;
    int items_sent;     // transfers accepted so far
    int hold_cycles;    // long receiver hold-off, counted down by the receiver
    int waited;
    bit src_gaps;
    bit sink_stalls;

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic response_t bus_response(logic kind, logic [7:0] txb, logic ack,
                                               logic stop, logic [7:0] mbyte,
                                               logic [3:0] midx, logic [4:0] mlen,
                                               logic last);
        response_t r;
        r.kind       = kind;
        r.tx_byte    = txb;
        r.ack_enable = ack;
        r.send_stop  = stop;
        r.busy       = busy_state;   // busy after the event has been applied
        r.msg_byte   = mbyte;
        r.msg_index  = midx;
        r.msg_length = mlen;
        r.last       = last;
        return r;
    endfunction

    // Applies one accepted transfer to the shadow state and queues what the
    // engine must answer.
    function automatic void predict_responses(bus_item_t it);
        int         limit;
        int         n;
        logic [7:0] txb;
        txb = i2ctb_pkg::NO_BYTE;
        // host write lands in the store, enabled or not; 4-bit index never
        // reaches past the 16-entry store
        if (it.mode == i2ctb_pkg::MODE_HOST)
        begin
            tx_mem[it.store_index] = it.store_data;
            return;
        end
        if (!en_cfg)
            return;
        case (it.code)
            i2ctb_pkg::EV_READ_START, i2ctb_pkg::EV_READ_ACK:
            begin
                if (it.code == i2ctb_pkg::EV_READ_START)
                    tx_pos = '0;
                // tx_length past the store depth acts as full depth
                limit = (int'(txlen_cfg) < i2ctb_pkg::TX_DEPTH)
                        ? int'(txlen_cfg) : i2ctb_pkg::TX_DEPTH;
                if (int'(tx_pos) < limit)
                begin
                    txb    = tx_mem[tx_pos[3:0]];
                    tx_pos = tx_pos + 5'd1;
                end
                busy_state = 1'b1;
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP, txb, 1'b1, 1'b0,
                                                       8'h00, 4'd0, 5'd0, 1'b1));
            end
            i2ctb_pkg::EV_READ_NACK:
            begin
                busy_state = 1'b0;
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP,
                                                       i2ctb_pkg::NO_BYTE, 1'b1, 1'b0,
                                                       8'h00, 4'd0, 5'd0, 1'b1));
            end
            i2ctb_pkg::EV_WRITE_START:
            begin
                rx_cnt     = '0;
                busy_state = 1'b1;
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP,
                                                       i2ctb_pkg::NO_BYTE, 1'b1, 1'b0,
                                                       8'h00, 4'd0, 5'd0, 1'b1));
            end
            i2ctb_pkg::EV_WRITE_BYTE:
            begin
                // receive overflow: byte dropped, count stays at depth
                if (int'(rx_cnt) < i2ctb_pkg::RX_DEPTH)
                begin
                    rx_mem[rx_cnt[3:0]] = it.rx_byte;
                    rx_cnt              = rx_cnt + 5'd1;
                end
                busy_state = 1'b1;
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP,
                                                       i2ctb_pkg::NO_BYTE, 1'b1, 1'b0,
                                                       8'h00, 4'd0, 5'd0, 1'b1));
            end
            i2ctb_pkg::EV_STOP:
            begin
                // kept bytes go out again even when no write came since
                busy_state = 1'b0;
                for (n = 0; n < int'(rx_cnt); n++)
                    awaited_results.push_back(bus_response(i2ctb_pkg::KIND_MSG,
                                                           i2ctb_pkg::NO_BYTE, 1'b1, 1'b0,
                                                           rx_mem[n], n[3:0], rx_cnt,
                                                           1'b0));
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP,
                                                       i2ctb_pkg::NO_BYTE, 1'b1, 1'b0,
                                                       8'h00, 4'd0, rx_cnt, 1'b1));
            end
            i2ctb_pkg::EV_ERROR:
            begin
                // busy left alone, stop requested, acknowledge dropped
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP,
                                                       i2ctb_pkg::NO_BYTE, 1'b0, 1'b1,
                                                       8'h00, 4'd0, 5'd0, 1'b1));
            end
            default:
            begin
                busy_state = 1'b0;
                awaited_results.push_back(bus_response(i2ctb_pkg::KIND_RESP,
                                                       i2ctb_pkg::NO_BYTE, 1'b1, 1'b0,
                                                       8'h00, 4'd0, 5'd0, 1'b1));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string show(response_t r);
        return {$sformatf("kind=%0d tx=%02h ack=%0d stop=%0d busy=%0d ",
                          r.kind, r.tx_byte, r.ack_enable, r.send_stop, r.busy),
                $sformatf("msg=%02h idx=%0d len=%0d last=%0d",
                          r.msg_byte, r.msg_index, r.msg_length, r.last)};
    endfunction

    task automatic check_transfer();
        response_t got;
        response_t want;
        got.kind       = result_ch.result_kind;
        got.tx_byte    = result_ch.tx_byte;
        got.ack_enable = result_ch.ack_enable;
        got.send_stop  = result_ch.send_stop;
        got.busy       = result_ch.busy_res;
        got.msg_byte   = result_ch.msg_byte;
        got.msg_index  = result_ch.msg_index;
        got.msg_length = result_ch.msg_length;
        got.last       = result_ch.last;
        if (awaited_results.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: unexpected result %s", $realtime, show(got));
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                got.ack_enable !== want.ack_enable || got.send_stop !== want.send_stop ||
                got.busy !== want.busy || got.msg_byte !== want.msg_byte ||
                got.msg_index !== want.msg_index || got.msg_length !== want.msg_length ||
                got.last !== want.last)
            begin
                bad_count++;
                if (bad_count <= 10)
                begin
                    $display("%0t: mismatch", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        end
    endtask

    // Values sampled at the edge are the ones from before it, so the
    // transfer seen here is the one the engine completed at this edge.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_transfer();
    end

    // Receiver: long hold-off first, then short random stall bursts.
    initial
    begin
        int burst;
        burst           = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                result_ch.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                burst           = $urandom_range(0, 3);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] rand_idx();
        return 4'($urandom_range(0, 15));
    endfunction

    // Bus event; store fields carry random junk so their bits toggle too.
    function automatic bus_item_t ev_item(i2ctb_pkg::event_t code, logic [7:0] rx_byte);
        bus_item_t it;
        it.mode        = i2ctb_pkg::MODE_BUS;
        it.code        = code;
        it.rx_byte     = rx_byte;
        it.store_index = rand_idx();
        it.store_data  = rand_byte();
        return it;
    endfunction

    function automatic bus_item_t host_item(logic [3:0] idx, logic [7:0] data);
        bus_item_t it;
        it.mode        = i2ctb_pkg::MODE_HOST;
        it.code        = i2ctb_pkg::event_t'($urandom_range(0, 7));
        it.rx_byte     = rand_byte();
        it.store_index = idx;
        it.store_data  = data;
        return it;
    endfunction

    // Offers one transfer and returns in the time step it is accepted.
    // valid is only dropped for a gap, so back-to-back transfers keep it high.
    task automatic send_item(bus_item_t it);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= it.mode;
        item_ch.event_code  <= it.code;
        item_ch.rx_byte     <= it.rx_byte;
        item_ch.store_index <= it.store_index;
        item_ch.store_data  <= it.store_data;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predict_responses(it);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result is in, then give the
    // engine time to finish any transfer that had nothing to return.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // APB write: setup phase, access phase, register updates on the edge
    // where the access completes.
    task automatic write_reg(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == i2ctb_pkg::REG_ENABLED)
        begin
            en_cfg     = value[0];
            busy_state = 1'b0;      // any write of enabled clears busy
        end
        else
            txlen_cfg = value[4:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic en, logic [4:0] len);
        settle();
        write_reg(i2ctb_pkg::REG_ENABLED, {31'd0, en});
        write_reg(i2ctb_pkg::REG_TX_LENGTH, {27'd0, len});
    endtask

    // One piece of traffic: mostly well-formed controller transactions with
    // random content, some host writes, errors and loose events.
    task automatic send_random_sequence();
        int n;
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                send_item(ev_item(i2ctb_pkg::EV_READ_START, rand_byte()));
                n = $urandom_range(0, 18);
                for (k = 0; k < n; k++)
                    send_item(ev_item(i2ctb_pkg::EV_READ_ACK, rand_byte()));
                if ($urandom_range(0, 3) != 0)
                    send_item(ev_item(i2ctb_pkg::EV_READ_NACK, rand_byte()));
                if ($urandom_range(0, 1) == 1)
                    send_item(ev_item(i2ctb_pkg::EV_STOP, rand_byte()));
            end
            3, 4, 5:
            begin
                send_item(ev_item(i2ctb_pkg::EV_WRITE_START, rand_byte()));
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(17, 20);
                else
                    n = $urandom_range(0, 16);
                for (k = 0; k < n; k++)
                    send_item(ev_item(i2ctb_pkg::EV_WRITE_BYTE, rand_byte()));
                if ($urandom_range(0, 7) != 0)
                    send_item(ev_item(i2ctb_pkg::EV_STOP, rand_byte()));
            end
            6:
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    send_item(host_item(rand_idx(), rand_byte()));
            end
            7:
            begin
                // transaction broken by a bus error
                send_item(ev_item(i2ctb_pkg::EV_WRITE_START, rand_byte()));
                n = $urandom_range(0, 4);
                for (k = 0; k < n; k++)
                    send_item(ev_item(i2ctb_pkg::EV_WRITE_BYTE, rand_byte()));
                send_item(ev_item(i2ctb_pkg::EV_ERROR, rand_byte()));
                send_item(ev_item(i2ctb_pkg::EV_STOP, rand_byte()));
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(host_item(rand_idx(), rand_byte()));
                else
                    send_item(ev_item(i2ctb_pkg::event_t'($urandom_range(0, 7)),
                                      rand_byte()));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every event code at least once, field extremes, disabled engine, repeated stop,
    // empty write, read past tx_length and with zero length.
    task automatic test_directed_basics();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        // engine still disabled after reset: host writes work, events vanish
        send_item(host_item(4'd0, 8'h00));
        send_item(host_item(4'd15, 8'hFF));
        send_item(host_item(4'd1, 8'h5A));
        send_item(host_item(4'd2, 8'hA5));
        send_item(ev_item(i2ctb_pkg::EV_READ_START, 8'h00));
        configure(1'b1, 5'd2);
        // read two stored bytes, then run off the end
        send_item(ev_item(i2ctb_pkg::EV_READ_START, 8'hFF));
        send_item(ev_item(i2ctb_pkg::EV_READ_ACK, 8'h00));
        send_item(ev_item(i2ctb_pkg::EV_READ_ACK, 8'hFF));
        send_item(ev_item(i2ctb_pkg::EV_READ_NACK, 8'h00));
        // two-byte message, delivered twice
        send_item(ev_item(i2ctb_pkg::EV_WRITE_START, 8'h00));
        send_item(ev_item(i2ctb_pkg::EV_WRITE_BYTE, 8'h00));
        send_item(ev_item(i2ctb_pkg::EV_WRITE_BYTE, 8'hFF));
        send_item(ev_item(i2ctb_pkg::EV_STOP, 8'h00));
        send_item(ev_item(i2ctb_pkg::EV_STOP, 8'hFF));
        send_item(ev_item(i2ctb_pkg::EV_ERROR, 8'h00));
        send_item(ev_item(i2ctb_pkg::EV_UNKNOWN, 8'hFF));
        // empty message
        send_item(ev_item(i2ctb_pkg::EV_WRITE_START, 8'h00));
        send_item(ev_item(i2ctb_pkg::EV_STOP, 8'h00));
        configure(1'b1, 5'd0);
        send_item(ev_item(i2ctb_pkg::EV_READ_START, 8'h00));
    endtask

    // Fill the whole transmit store so any tx_length can be read later.
    task automatic test_store_fill();
        int k;
        for (k = 0; k < i2ctb_pkg::TX_DEPTH; k++)
            send_item(host_item(k[3:0], rand_byte()));
    endtask

    // Full-length and over-long tx_length reads, receive overflow.
    task automatic test_length_extremes();
        int k;
        configure(1'b1, 5'd16);
        send_item(ev_item(i2ctb_pkg::EV_READ_START, rand_byte()));
        for (k = 0; k < i2ctb_pkg::TX_DEPTH; k++)
            send_item(ev_item(i2ctb_pkg::EV_READ_ACK, rand_byte()));
        configure(1'b1, 5'd31);
        send_item(ev_item(i2ctb_pkg::EV_READ_START, rand_byte()));
        for (k = 0; k < i2ctb_pkg::TX_DEPTH; k++)
            send_item(ev_item(i2ctb_pkg::EV_READ_ACK, rand_byte()));
        send_item(ev_item(i2ctb_pkg::EV_WRITE_START, rand_byte()));
        for (k = 0; k < i2ctb_pkg::RX_DEPTH + 4; k++)
            send_item(ev_item(i2ctb_pkg::EV_WRITE_BYTE, rand_byte()));
        send_item(ev_item(i2ctb_pkg::EV_STOP, rand_byte()));
    endtask

    // Receiver holds off for a long time while the sender keeps offering:
    // the output register fills, unloading stalls, and the input backs up.
    task automatic test_backpressure();
        int k;
        configure(1'b1, 5'd16);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        hold_cycles = 300;
        for (k = 0; k < 2; k++)
        begin
            send_item(ev_item(i2ctb_pkg::EV_WRITE_START, rand_byte()));
            repeat (i2ctb_pkg::RX_DEPTH)
                send_item(ev_item(i2ctb_pkg::EV_WRITE_BYTE, rand_byte()));
            send_item(ev_item(i2ctb_pkg::EV_STOP, rand_byte()));
        end
        send_item(ev_item(i2ctb_pkg::EV_READ_START, rand_byte()));
        send_item(ev_item(i2ctb_pkg::EV_READ_ACK, rand_byte()));
        send_item(ev_item(i2ctb_pkg::EV_READ_NACK, rand_byte()));
        // sender pauses until the engine has answered everything
        settle();
    endtask

    // Random phases, each with its own register setting and idling mix.
    task automatic test_random_traffic();
        int   phase;
        int   goal;
        logic [4:0] len;
        for (phase = 0; phase < 4; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       len = 5'd0;
                1:       len = 5'd16;
                2:       len = 5'($urandom_range(17, 31));
                default: len = 5'($urandom_range(1, 15));
            endcase
            configure($urandom_range(0, 5) != 0, len);
            src_gaps    = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
            goal        = items_sent + 10;
            while (items_sent < goal)
                send_random_sequence();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_final_stretch();
        int goal;
        configure(1'b1, 5'($urandom_range(1, 16)));
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        goal        = items_sent + 10;
        while (items_sent < goal)
            send_random_sequence();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = i2ctb_pkg::MODE_BUS;
        item_ch.event_code  = i2ctb_pkg::EV_READ_START;
        item_ch.rx_byte     = 8'h00;
        item_ch.store_index = 4'd0;
        item_ch.store_data  = 8'h00;
        en_cfg              = 1'b0;
        txlen_cfg           = '0;
        tx_pos              = '0;
        rx_cnt              = '0;
        busy_state          = 1'b0;
        bad_count           = 0;
        items_sent          = 0;
        hold_cycles         = 0;
        src_gaps            = 1'b0;
        sink_stalls         = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_store_fill();
        test_length_extremes();
        test_backpressure();
        test_random_traffic();
        test_final_stretch();

        // drain: wait for the last results, bounded, then idle before the verdict
        item_ch.valid <= 1'b0;
        waited = 0;
        while (awaited_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (24) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            bad_count += awaited_results.size();
            $display("%0d expected results never arrived", awaited_results.size());
        end

        if (bad_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/i2ctb_pkg.sv
rtl/i2ctb_item_if.sv
rtl/i2ctb_result_if.sv
rtl/i2ctb_ctrl.sv
rtl/i2ctb_dpath.sv
rtl/i2ctb_top_note.sv
rtl/i2c_target_byte_buffer_engine.sv
sim/tb_top.sv
